/* rtl/dccs_pkg.sv */
// Package for the depthwise causal convolution block with SiLU.
// Holds opcodes, register indexes, shared types and the sigmoid table.
// No dependencies.
`default_nettype none

package dccs_pkg;

    localparam int CHANNELS_DEF = 256;
    localparam int MAX_TAPS_DEF = 4;

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_PRELOAD = 2'd1;
    localparam logic [1:0] OP_WEIGHT  = 2'd2;
    localparam logic [1:0] OP_BIAS    = 2'd3;

    localparam logic [7:0] REG_TAPS = 8'd0;
    localparam logic [7:0] REG_ACT  = 8'd1;
    localparam logic [7:0] REG_BIAS = 8'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         channel;
        logic [1:0]         tap;
        logic signed [15:0] value;
    } cmd_t;

    typedef struct packed {
        logic [2:0] taps_in_use;
        logic       activation_on;
        logic       bias_on;
    } cfg_t;

    typedef logic [15:0] sig_table_t [256];

    // Restoring long division, used only while the table is elaborated.
    function automatic longint unsigned long_div(longint unsigned num,
                                                 longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        int              b;
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                q   = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // Sigmoid at bin midpoints (2i-255)/32, Q0.16, from a fixed e^-1/16 step.
    function automatic sig_table_t build_sigmoid();
        sig_table_t      t;
        longint unsigned r;
        longint unsigned r2;
        longint unsigned p;
        longint unsigned den;
        longint unsigned sig;
        int              i;
        r  = 64'd4162825044;
        r2 = (r * r + 64'h8000_0000) >> 32;
        p  = r;
        for (i = 128; i < 256; i++)
        begin
            den = (64'd1 << 32) + p;
            sig = long_div((64'd1 << 48) + (den >> 1), den);
            t[i] = sig[15:0];
            t[255 - i] = 16'(32'd65536 - sig[31:0]);
            p = (p * r2 + 64'h8000_0000) >> 32;
        end
        return t;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sigmoid();

endpackage

`default_nettype wire

/* rtl/dccs_front.sv */
// Front end: accepts items, drops those for absent channels or taps,
// and holds the rest in a two-entry queue. Depends on dccs_pkg.
`default_nettype none

module dccs_front #(
    parameter int CHANNELS = 256,
    parameter int MAX_TAPS = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     opcode,
    input  wire logic [7:0]     channel,
    input  wire logic [1:0]     tap,
    input  wire logic [15:0]    value,
    input  wire logic           clearing,
    output logic                q_valid,
    input  wire logic           q_ready,
    output dccs_pkg::cmd_t      q_cmd
);
    import dccs_pkg::*;

    cmd_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       keep;
    logic       push;
    logic       pop;

    assign keep = (int'(channel) < CHANNELS) &&
                  !((opcode == OP_WEIGHT) && (int'(tap) >= MAX_TAPS));
    assign in_ready = !clearing && (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_cmd    = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= '{opcode: opcode, channel: channel, tap: tap,
                                     value: value};
        end
    end

endmodule

`default_nettype wire

/* rtl/dccs_back.sv */
// Back end: coefficient and history memories, tap-serial MAC, rounding,
// SiLU and saturation, and the result register. Depends on dccs_pkg.
`default_nettype none

module dccs_back #(
    parameter int CHANNELS = 256,
    parameter int MAX_TAPS = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  dccs_pkg::cfg_t      cfg,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  dccs_pkg::cmd_t      q_cmd,
    output logic                clearing,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [15:0]         out_value,
    output logic [7:0]          out_channel,
    output logic                saturated
);
    import dccs_pkg::*;

    localparam int HIST_LEN = MAX_TAPS - 1;
    localparam int W_DEPTH  = CHANNELS * MAX_TAPS;
    localparam int H_DEPTH  = CHANNELS * HIST_LEN;
    localparam int WA_W     = $clog2(W_DEPTH);
    localparam int HA_W     = (H_DEPTH > 1) ? $clog2(H_DEPTH) : 1;
    localparam int BA_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TI_W     = $clog2(MAX_TAPS);
    localparam int HI_W     = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int K_W      = (CNT_W > 3) ? CNT_W : 3;
    localparam int ACC_W    = 33 + $clog2(MAX_TAPS);
    localparam int S_W      = ACC_W - 12;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_MAC   = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;
    localparam logic [2:0] ST_ROUND = 3'd5;
    localparam logic [2:0] ST_ACT   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic signed [S_W-1:0] Y_MAX = S_W'(32767);
    localparam logic signed [S_W-1:0] Y_MIN = S_W'(-32768);

    logic [2:0]              state_reg;
    logic [WA_W-1:0]         clr_reg;
    logic [CNT_W-1:0]        cnt_reg;
    cmd_t                    cmd_reg;
    logic signed [15:0]      w_loc_reg [MAX_TAPS];
    logic signed [15:0]      h_loc_reg [HIST_LEN];
    logic signed [15:0]      bias_loc_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [S_W-1:0]   s_reg;
    logic signed [S_W-1:0]   y_reg;
    logic                    out_valid_reg;
    logic [15:0]             out_value_reg;
    logic [7:0]              out_channel_reg;
    logic                    saturated_reg;

    logic [15:0] w_mem [W_DEPTH];
    logic [15:0] h_mem [H_DEPTH];
    logic [15:0] b_mem [CHANNELS];
    logic [15:0] w_q, h_q, b_q;

    logic            w_we, h_we, b_we;
    logic [WA_W-1:0] w_wa, w_ra;
    logic [HA_W-1:0] h_wa, h_ra;
    logic [BA_W-1:0] b_wa, b_ra;
    logic [15:0]     w_wd, h_wd, b_wd;

    logic [K_W-1:0]          taps_ext;
    logic [K_W-1:0]          k_eff;
    logic signed [15:0]      mac_w;
    logic signed [15:0]      mac_x;
    logic signed [31:0]      mac_prod;
    logic signed [32:0]      act_prod;
    logic [15:0]             sig_val;
    logic signed [S_W-1:0]   y_next;
    logic                    out_free;
    logic                    sat_hi, sat_lo;

    assign clearing = (state_reg == ST_CLEAR);
    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign taps_ext = K_W'(cfg.taps_in_use);
    assign k_eff = (taps_ext > K_W'(MAX_TAPS)) ? K_W'(MAX_TAPS) :
                   (taps_ext == '0) ? K_W'(1) : taps_ext;

    // Tap K-1 meets the new sample, tap K-1-d the sample d steps older.
    assign mac_w = w_loc_reg[TI_W'(k_eff - K_W'(1) - K_W'(cnt_reg))];
    assign mac_x = (cnt_reg == '0) ? cmd_reg.value
                                   : h_loc_reg[HI_W'(HIST_LEN - int'(cnt_reg))];
    assign mac_prod = mac_w * mac_x;

    assign sig_val  = SIG_TABLE[{~s_reg[15], s_reg[14:8]}];
    assign act_prod = $signed(s_reg[15:0]) * $signed({1'b0, sig_val});

    always_comb
    begin
        if (!cfg.activation_on)
            y_next = s_reg;
        else if (s_reg < Y_MIN)
            y_next = '0;
        else if (s_reg > Y_MAX)
            y_next = s_reg;
        else
            y_next = S_W'((act_prod + 33'sd32768) >>> 16);
    end

    assign sat_hi = (y_reg > Y_MAX);
    assign sat_lo = (y_reg < Y_MIN);

    // Memory ports
    always_comb
    begin
        w_we = 1'b0;
        h_we = 1'b0;
        b_we = 1'b0;
        w_wa = WA_W'(int'(q_cmd.channel) * MAX_TAPS + int'(q_cmd.tap));
        h_wa = HA_W'(int'(cmd_reg.channel) * HIST_LEN + int'(cnt_reg));
        b_wa = BA_W'(q_cmd.channel);
        w_wd = q_cmd.value;
        b_wd = q_cmd.value;
        h_wd = (int'(cnt_reg) == HIST_LEN - 1) ? cmd_reg.value
                                                : h_loc_reg[HI_W'(int'(cnt_reg) + 1)];
        w_ra = WA_W'(int'(cmd_reg.channel) * MAX_TAPS + int'(cnt_reg));
        h_ra = HA_W'(int'(cmd_reg.channel) * HIST_LEN + int'(cnt_reg));
        b_ra = BA_W'(cmd_reg.channel);
        unique case (state_reg)
            ST_CLEAR:
            begin
                w_we = 1'b1;
                h_we = (int'(clr_reg) < H_DEPTH);
                b_we = (int'(clr_reg) < CHANNELS);
                w_wa = clr_reg;
                h_wa = HA_W'(clr_reg);
                b_wa = BA_W'(clr_reg);
                w_wd = '0;
                h_wd = '0;
                b_wd = '0;
            end
            ST_IDLE:
            begin
                w_we = q_valid && (q_cmd.opcode == OP_WEIGHT);
                b_we = q_valid && (q_cmd.opcode == OP_BIAS);
            end
            ST_WB:
            begin
                h_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_wa] <= w_wd;
        w_q <= w_mem[w_ra];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            h_mem[h_wa] <= h_wd;
        h_q <= h_mem[h_ra];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            b_mem[b_wa] <= b_wd;
        b_q <= b_mem[b_ra];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop the result once taken, unless a new one loads this cycle
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (int'(clr_reg) == W_DEPTH - 1)
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (q_valid && ((q_cmd.opcode == OP_DATA) ||
                                    (q_cmd.opcode == OP_PRELOAD)))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    if (int'(cnt_reg) == MAX_TAPS)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (cmd_reg.opcode == OP_DATA) ? ST_MAC : ST_WB;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_MAC:
                begin
                    if (K_W'(cnt_reg) == k_eff - K_W'(1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_WB;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_WB:
                begin
                    if (int'(cnt_reg) == HIST_LEN - 1)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (cmd_reg.opcode == OP_DATA) ? ST_ROUND : ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ROUND:
                begin
                    state_reg <= ST_ACT;
                end
                ST_ACT:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && q_valid)
            cmd_reg <= q_cmd;
        if ((state_reg == ST_FETCH) && (cnt_reg != '0))
        begin
            w_loc_reg[TI_W'(cnt_reg - 1'b1)] <= w_q;
            if (int'(cnt_reg) <= HIST_LEN)
                h_loc_reg[HI_W'(cnt_reg - 1'b1)] <= h_q;
            if (cnt_reg == CNT_W'(1))
                bias_loc_reg <= b_q;
        end
        if ((state_reg == ST_FETCH) && (int'(cnt_reg) == MAX_TAPS))
            acc_reg <= cfg.bias_on ? (ACC_W'(bias_loc_reg) <<< 12) : '0;
        else if (state_reg == ST_MAC)
            acc_reg <= acc_reg + ACC_W'(mac_prod);
        if (state_reg == ST_ROUND)
            s_reg <= S_W'((acc_reg + ACC_W'(2048)) >>> 12);
        if (state_reg == ST_ACT)
            y_reg <= y_next;
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_value_reg   <= sat_hi ? 16'h7FFF : sat_lo ? 16'h8000 : y_reg[15:0];
            out_channel_reg <= cmd_reg.channel;
            saturated_reg   <= sat_hi || sat_lo;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign out_channel = out_channel_reg;
    assign saturated   = saturated_reg;

endmodule

`default_nettype wire

/* rtl/depthwise_causal_conv_silu.sv */
// Top level of the depthwise causal convolution with bias and SiLU.
// Holds the configuration registers; uses dccs_pkg, dccs_front, dccs_back.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    opcode, channel, tap, value
//   result    out_valid / out_ready  out_value, out_channel, saturated
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A data sample passes through the tap-serial fetch, multiply-accumulate and
// history write-back, on one memory port each, then rounding, SiLU and output;
// a preload only fetches and writes back, a weight or bias write is taken in idle.
// After reset the memories are cleared, all CHANNELS*MAX_TAPS weight words, with
// in_ready low. A two-entry queue and the result register absorb stalls on
// either side; a result stall that lasts holds up the input once the queue fills.
`default_nettype none

module depthwise_causal_conv_silu #(
    parameter int CHANNELS = dccs_pkg::CHANNELS_DEF,
    parameter int MAX_TAPS = dccs_pkg::MAX_TAPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  channel,
    input  wire logic [1:0]  tap,
    input  wire logic [15:0] value,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_value,
    output logic [7:0]       out_channel,
    output logic             saturated,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import dccs_pkg::*;

    cfg_t cfg_reg;
    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;
    logic clearing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{taps_in_use: 3'd4, activation_on: 1'b1, bias_on: 1'b1};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TAPS: cfg_reg.taps_in_use   <= cfg_data[2:0];
                REG_ACT:  cfg_reg.activation_on <= cfg_data[0];
                REG_BIAS: cfg_reg.bias_on       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    dccs_front #(
        .CHANNELS (CHANNELS),
        .MAX_TAPS (MAX_TAPS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .channel  (channel),
        .tap      (tap),
        .value    (value),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_cmd    (q_cmd)
    );

    dccs_back #(
        .CHANNELS (CHANNELS),
        .MAX_TAPS (MAX_TAPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_cmd       (q_cmd),
        .clearing    (clearing),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_value   (out_value),
        .out_channel (out_channel),
        .saturated   (saturated)
    );

endmodule

`default_nettype wire

/* rtl/dccs_check.sv */
// Port-level checks for depthwise_causal_conv_silu, bound to the top level.
// Depends on dccs_pkg and the top level's ports.
`default_nettype none

module dccs_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] out_value,
    input wire logic [7:0]  out_channel,
    input wire logic        saturated,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [7:0]  cfg_index,
    input wire logic [7:0]  cfg_data
);
    import dccs_pkg::*;

    logic act_on_reg;

    // Track the activation switch from the config transfers seen on the port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_on_reg <= 1'b1;
        else if (cfg_valid && cfg_ready && (cfg_index == REG_ACT))
            act_on_reg <= cfg_data[0];
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value) &&
                                    $stable(out_channel) && $stable(saturated))
        else $error("result changed while stalled");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (out_value == 16'h7FFF || out_value == 16'h8000))
        else $error("saturated result not at a range limit");

    a_silu_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && act_on_reg |-> !(saturated && out_value[15]))
        else $error("negative clip with SiLU enabled");

endmodule

bind depthwise_causal_conv_silu dccs_check u_dccs_check (.*);

`default_nettype wire
